>>> rtl/assert_macros.svh
// assertion helpers shared by the rtl, sampled on clk and idle during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/pfc_pkg.sv
package pfc_pkg;

	// default flow table depth
	localparam int unsigned FLOW_ENTRIES_DEF = 256;

	// protocol numbers that are tracked
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	// counter widths
	localparam int unsigned PKT_W   = 32;
	localparam int unsigned BYTE_W  = 48;
	localparam int unsigned FLOW_W  = 9;
	localparam int unsigned MEAS_W  = 17;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_UPDATE
	} state_t;

	// one flow table entry
	typedef struct packed {
		logic        is_udp;
		logic [31:0] port_pair;
		logic [31:0] dst_addr;
		logic [31:0] src_addr;
	} flow_entry_t;

	// input request, last declared field in the lowest bits
	typedef struct packed {
		logic [3:0]  pad;
		logic [3:0]  header_words;
		logic [15:0] total_length;
		logic [15:0] dport;
		logic [15:0] sport;
		logic [31:0] dst_addr;
		logic [31:0] src_addr;
		logic [7:0]  ip_protocol;
	} in_req_t;

	// result, last declared field in the lowest bits
	typedef struct packed {
		logic [2:0]        pad;
		logic              table_full;
		logic              new_flow;
		logic [FLOW_W-1:0] udp_flows;
		logic [FLOW_W-1:0] tcp_flows;
		logic [FLOW_W-1:0] flows_total;
		logic [BYTE_W-1:0] udp_bytes;
		logic [BYTE_W-1:0] tcp_bytes;
		logic [PKT_W-1:0]  udp_packets;
		logic [PKT_W-1:0]  tcp_packets;
		logic [PKT_W-1:0]  packets_seen;
	} result_t;

	localparam int unsigned IN_DATA_W  = $bits(in_req_t);
	localparam int unsigned OUT_DATA_W = $bits(result_t);

endpackage

>>> rtl/pfc_ram.sv
module pfc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/packet_flow_counter_unit.sv
// Per-packet IPv4 traffic statistics with a bounded five-tuple flow table.
// Input stream s_axis: one parsed IPv4 header per request. Output stream
// m_axis: exactly one result per request, in order, carrying every counter
// after the update plus the new_flow and table_full flags.
// TCP and UDP requests search the flow table, held in a single-port-read
// RAM, one entry per cycle from the oldest entry up; a hit ends the search.
// A miss appends the flow if room is left, else table_full is reported.
// After acceptance, other protocols go straight to the update state, while TCP
// and UDP requests first search the used entries; the update registers the result.
// One request is in work at a time, so the rate is set by the RAM read
// port while the receiver does not stall; a full table gives the longest search.
// A finished result sits in the output register while the next request is
// accepted; if the receiver stalls, the following request waits before its
// update until that register is free, and s_axis_tready stays low meanwhile.
// Reset clears all counters and the flow count; table contents are never
// cleared, as only entries below the flow count are ever read.
`include "assert_macros.svh"

module packet_flow_counter_unit #(
	parameter int unsigned FLOW_ENTRIES = pfc_pkg::FLOW_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// ip_protocol, src_addr, dst_addr, sport, dport, total_length,
	// header_words, zero pad
	input  logic [pfc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// packets_seen, tcp_packets, udp_packets, tcp_bytes, udp_bytes,
	// flows_total, tcp_flows, udp_flows, new_flow, table_full, zero pad
	output logic [pfc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

	localparam int unsigned AW = $clog2(FLOW_ENTRIES);
	localparam int unsigned CW = $clog2(FLOW_ENTRIES + 1);
	localparam int unsigned EW = $bits(pfc_pkg::flow_entry_t);

	pfc_pkg::state_t      state_q, state_d;
	pfc_pkg::in_req_t     req;
	pfc_pkg::flow_entry_t probe_q;
	pfc_pkg::flow_entry_t rd_entry;
	pfc_pkg::result_t     res_d, res_q;

	logic                        is_flow_q;
	logic [pfc_pkg::MEAS_W-1:0]  measure_q;
	logic                        found_q;
	logic [CW-1:0]               issue_q;
	logic                        rd_pend_s1;
	logic [CW-1:0]               entries_used_q;
	logic [CW-1:0]               tcp_entries_q;
	logic [pfc_pkg::PKT_W-1:0]   packets_q, tcp_pkts_q, udp_pkts_q;
	logic [pfc_pkg::BYTE_W-1:0]  tcp_bytes_q, udp_bytes_q;
	logic                        out_valid_q;

	logic                        accept;
	logic                        req_is_flow;
	logic                        hit;
	logic                        more_to_read;
	logic                        out_free;
	logic                        rd_en;
	logic                        wr_en;
	logic                        update_en;
	logic                        table_at_max;
	logic                        is_new;
	logic                        dropped;
	logic [CW-1:0]               used_nx, tcp_used_nx;
	logic [pfc_pkg::PKT_W-1:0]   packets_nx, tcp_pkts_nx, udp_pkts_nx;
	logic [pfc_pkg::BYTE_W:0]    tcp_sum, udp_sum;
	logic [pfc_pkg::BYTE_W-1:0]  tcp_bytes_nx, udp_bytes_nx;

	assign req         = pfc_pkg::in_req_t'(s_axis_tdata);
	assign accept      = s_axis_tvalid && s_axis_tready;
	assign req_is_flow = (req.ip_protocol == pfc_pkg::PROTO_TCP) ||
		(req.ip_protocol == pfc_pkg::PROTO_UDP);
	assign hit          = rd_pend_s1 && (rd_entry == probe_q);
	assign more_to_read = issue_q < entries_used_q;
	assign out_free     = !out_valid_q || m_axis_tready;
	assign table_at_max = entries_used_q == CW'(FLOW_ENTRIES);
	assign is_new       = is_flow_q && !found_q && !table_at_max;
	assign dropped      = is_flow_q && !found_q && table_at_max;

	// flow table storage
	pfc_ram #(
		.WIDTH (EW),
		.DEPTH (FLOW_ENTRIES)
	) u_flow_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (entries_used_q[AW-1:0]),
		.wr_data (probe_q),
		.rd_en   (rd_en),
		.rd_addr (issue_q[AW-1:0]),
		.rd_data (rd_entry)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pfc_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = req_is_flow ? pfc_pkg::ST_SEARCH : pfc_pkg::ST_UPDATE;
				end
			end
			pfc_pkg::ST_SEARCH: begin
				if (hit || (!more_to_read && !rd_pend_s1)) begin
					state_d = pfc_pkg::ST_UPDATE;
				end
			end
			pfc_pkg::ST_UPDATE: begin
				if (out_free) begin
					state_d = pfc_pkg::ST_IDLE;
				end
			end
			default: state_d = pfc_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_axis_tready = 1'b0;
		rd_en         = 1'b0;
		update_en     = 1'b0;
		unique case (state_q)
			pfc_pkg::ST_IDLE:   s_axis_tready = 1'b1;
			pfc_pkg::ST_SEARCH: rd_en = !hit && more_to_read;
			pfc_pkg::ST_UPDATE: update_en = out_free;
			default: s_axis_tready = 1'b0;
		endcase
		wr_en = update_en && is_new;
	end

	// saturating counter updates
	always_comb begin
		packets_nx   = (&packets_q) ? packets_q : packets_q + 1'b1;
		tcp_pkts_nx  = tcp_pkts_q;
		udp_pkts_nx  = udp_pkts_q;
		tcp_bytes_nx = tcp_bytes_q;
		udp_bytes_nx = udp_bytes_q;
		tcp_sum = {1'b0, tcp_bytes_q} + (pfc_pkg::BYTE_W + 1)'(measure_q);
		udp_sum = {1'b0, udp_bytes_q} + (pfc_pkg::BYTE_W + 1)'(measure_q);
		if (is_flow_q) begin
			if (probe_q.is_udp) begin
				udp_pkts_nx  = (&udp_pkts_q) ? udp_pkts_q : udp_pkts_q + 1'b1;
				udp_bytes_nx = udp_sum[pfc_pkg::BYTE_W] ? '1 :
					udp_sum[pfc_pkg::BYTE_W-1:0];
			end else begin
				tcp_pkts_nx  = (&tcp_pkts_q) ? tcp_pkts_q : tcp_pkts_q + 1'b1;
				tcp_bytes_nx = tcp_sum[pfc_pkg::BYTE_W] ? '1 :
					tcp_sum[pfc_pkg::BYTE_W-1:0];
			end
		end
		used_nx     = is_new ? entries_used_q + 1'b1 : entries_used_q;
		tcp_used_nx = (is_new && !probe_q.is_udp) ? tcp_entries_q + 1'b1 : tcp_entries_q;
	end

	// result word
	always_comb begin
		res_d              = '0;
		res_d.packets_seen = packets_nx;
		res_d.tcp_packets  = tcp_pkts_nx;
		res_d.udp_packets  = udp_pkts_nx;
		res_d.tcp_bytes    = tcp_bytes_nx;
		res_d.udp_bytes    = udp_bytes_nx;
		res_d.flows_total  = pfc_pkg::FLOW_W'(used_nx);
		res_d.tcp_flows    = pfc_pkg::FLOW_W'(tcp_used_nx);
		res_d.udp_flows    = pfc_pkg::FLOW_W'(used_nx - tcp_used_nx);
		res_d.new_flow     = is_new;
		res_d.table_full   = dropped;
	end

	// control and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= pfc_pkg::ST_IDLE;
			found_q        <= 1'b0;
			issue_q        <= '0;
			rd_pend_s1     <= 1'b0;
			entries_used_q <= '0;
			tcp_entries_q  <= '0;
			packets_q      <= '0;
			tcp_pkts_q     <= '0;
			udp_pkts_q     <= '0;
			tcp_bytes_q    <= '0;
			udp_bytes_q    <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= rd_en;
			if (accept) begin
				found_q <= 1'b0;
				issue_q <= '0;
			end else begin
				if (hit) begin
					found_q <= 1'b1;
				end
				if (rd_en) begin
					issue_q <= issue_q + 1'b1;
				end
			end
			if (update_en) begin
				entries_used_q <= used_nx;
				tcp_entries_q  <= tcp_used_nx;
				packets_q      <= packets_nx;
				tcp_pkts_q     <= tcp_pkts_nx;
				udp_pkts_q     <= udp_pkts_nx;
				tcp_bytes_q    <= tcp_bytes_nx;
				udp_bytes_q    <= udp_bytes_nx;
			end
			if (update_en) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			is_flow_q         <= req_is_flow;
			probe_q.src_addr  <= req.src_addr;
			probe_q.dst_addr  <= req.dst_addr;
			probe_q.port_pair <= {req.sport, req.dport};
			probe_q.is_udp    <= req.ip_protocol == pfc_pkg::PROTO_UDP;
			measure_q         <= pfc_pkg::MEAS_W'(req.total_length) +
				pfc_pkg::MEAS_W'({req.header_words, 2'b00});
		end
		if (update_en) begin
			res_q <= res_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = res_q;

	// checks
	`ASSERT_ALWAYS(a_tcp_le_used, tcp_entries_q <= entries_used_q,
		"tcp flow count above total flow count")
	`ASSERT_ALWAYS(a_read_in_range, !rd_en || (issue_q < entries_used_q),
		"flow table read beyond used entries")
	`ASSERT_ALWAYS(a_flags_excl, !out_valid_q || !(res_q.new_flow && res_q.table_full),
		"new flow and table full both set")
	`ASSERT_NEXT(a_result_from_update, !out_valid_q && (state_q != pfc_pkg::ST_UPDATE),
		!out_valid_q, "result raised without an update")

endmodule
